>>> hw/rtl/octc_pkg.sv
// Shared types and constants for the octree child tile subdivision block.
package octc_pkg;

   localparam int COORD_BITS  = 32;
   localparam int DEPTH_LIMIT = 23;
   localparam int DEPTH_W     = 5;
   localparam int PIDX_W      = 23;
   localparam int CIDX_W      = DEPTH_LIMIT + 1;
   localparam int PMULT_W     = 16;
   localparam int CMULT_W     = PMULT_W + 1;
   localparam int FLAGS_W     = 9;
   localparam int NUM_CHILD   = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_VALID  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_X      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_Z      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_X     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_Y     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_Z     = 3'd7;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic                plane_mode;
      logic                box_valid;
      coord_type [2:0]     low;
      coord_type [2:0]     high;
   } octc_cfg_type;

   // One classified parent; keep is indexed by emission order {i, j, k}.
   typedef struct packed {
      logic                  magnify;
      logic                  plane;
      logic [DEPTH_W-1:0]    depth;
      logic [PIDX_W-1:0]     idx_i;
      logic [PIDX_W-1:0]     idx_j;
      logic [PIDX_W-1:0]     idx_k;
      logic [CMULT_W-1:0]    mult;
      logic [NUM_CHILD-1:0]  keep;
      coord_type [2:0]       low;
      coord_type [2:0]       mid;
      coord_type [2:0]       high;
   } octc_desc_type;

   typedef struct packed {
      logic [DEPTH_W-1:0]    depth;
      logic [CIDX_W-1:0]     idx_i;
      logic [CIDX_W-1:0]     idx_j;
      logic [CIDX_W-1:0]     idx_k;
      logic [CMULT_W-1:0]    mult;
      coord_type [2:0]       low;
      coord_type [2:0]       high;
      logic                  last;
   } octc_rsp_type;

endpackage

>>> hw/rtl/octc_front.sv
// Front end: accepts a parent request, splits its box and picks the children to emit.
module octc_front (
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [octc_pkg::DEPTH_W-1:0]   req_parent_depth,
   input  logic [octc_pkg::PIDX_W-1:0]    req_parent_i,
   input  logic [octc_pkg::PIDX_W-1:0]    req_parent_j,
   input  logic [octc_pkg::PIDX_W-1:0]    req_parent_k,
   input  logic [octc_pkg::PMULT_W-1:0]   req_parent_mult,
   input  logic [octc_pkg::FLAGS_W-1:0]   req_leaf_and_empty,
   input  octc_pkg::coord_type [2:0]      req_low,
   input  octc_pkg::coord_type [2:0]      req_high,
   input  octc_pkg::octc_cfg_type         cfg,
   input  logic                           q_full,
   output logic                           q_push,
   output octc_pkg::octc_desc_type        q_data
);
   import octc_pkg::*;

   logic [COORD_BITS:0]    sum [3];
   coord_type [2:0]        mid;
   logic [2:0][1:0]        hit;
   logic                   contained;
   logic                   reject_test;
   logic [NUM_CHILD-1:0]   keep;
   logic [2:0]             ebit;
   coord_type              clo;
   coord_type              chi;
   logic                   is_leaf;
   logic                   magnify;

   assign req_ready = !q_full;
   assign is_leaf   = req_leaf_and_empty[FLAGS_W-1];
   assign magnify   = (req_parent_mult != '0);

   always_comb begin
      contained = 1'b1;
      for (int a = 0; a < 3; a++) begin
         sum[a] = {req_low[a][COORD_BITS-1], req_low[a]}
                + {req_high[a][COORD_BITS-1], req_high[a]};
         mid[a] = sum[a][COORD_BITS:1];
         if (!($signed(cfg.low[a]) <= $signed(req_low[a]) &&
               $signed(req_high[a]) <= $signed(cfg.high[a])))
            contained = 1'b0;
         for (int h = 0; h < 2; h++) begin
            if (a == 2 && cfg.plane_mode) begin
               clo = req_low[a];
               chi = req_high[a];
            end else begin
               clo = (h == 1) ? mid[a] : req_low[a];
               chi = (h == 1) ? req_high[a] : mid[a];
            end
            hit[a][h] = ($signed(clo) <= $signed(cfg.high[a])) &&
                        ($signed(cfg.low[a]) <= $signed(chi));
         end
      end
      reject_test = cfg.box_valid && !contained;
      for (int o = 0; o < NUM_CHILD; o++) begin
         ebit    = {o[0], o[1], o[2]};
         keep[o] = !req_leaf_and_empty[ebit]
                 && !(cfg.plane_mode && o[0])
                 && (!reject_test || (hit[0][o[2]] && hit[1][o[1]] && hit[2][o[0]]));
      end
   end

   always_comb begin
      q_data.magnify = magnify;
      q_data.plane   = cfg.plane_mode;
      q_data.depth   = req_parent_depth;
      q_data.idx_i   = req_parent_i;
      q_data.idx_j   = req_parent_j;
      q_data.idx_k   = req_parent_k;
      q_data.mult    = {req_parent_mult, 1'b0};
      q_data.keep    = magnify ? NUM_CHILD'(1) : keep;
      q_data.low     = req_low;
      q_data.mid     = mid;
      q_data.high    = req_high;
   end

   assign q_push = req_valid && req_ready && !is_leaf && (q_data.keep != '0);

endmodule

>>> hw/rtl/octc_queue.sv
// Two-entry queue of classified parents between front and back ends.
module octc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  octc_pkg::octc_desc_type  push_data,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output octc_pkg::octc_desc_type  head
);
   import octc_pkg::*;

   octc_desc_type        entry_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QCNT_W-1:0]    count_ff;
   logic [QCNT_W-1:0]    count_in;
   logic                 do_pop;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (!push && do_pop)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push)
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

endmodule

>>> hw/rtl/octc_back.sv
// Back end: walks the head's kept children into the output register, one per unstalled cycle.
module octc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  octc_pkg::octc_desc_type  head,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output octc_pkg::octc_rsp_type   rsp
);
   import octc_pkg::*;

   logic                   started_ff;
   logic [NUM_CHILD-1:0]   rem_ff;
   logic [NUM_CHILD-1:0]   rem;
   logic [NUM_CHILD-1:0]   rem_in;
   logic [2:0]             sel;
   logic                   emit;
   logic                   last;
   logic                   rsp_valid_ff;
   octc_rsp_type           rsp_ff;
   octc_rsp_type           rsp_in;

   assign rem  = started_ff ? rem_ff : head.keep;
   assign emit = head_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      sel = '0;
      for (int n = NUM_CHILD - 1; n >= 0; n--)
         if (rem[n])
            sel = 3'(n);
      rem_in      = rem;
      rem_in[sel] = 1'b0;
      last        = (rem_in == '0);
   end

   assign q_pop = emit && last;

   always_comb begin
      rsp_in.last = last;
      if (head.magnify) begin
         rsp_in.depth = head.depth;
         rsp_in.idx_i = {1'b0, head.idx_i};
         rsp_in.idx_j = {1'b0, head.idx_j};
         rsp_in.idx_k = {1'b0, head.idx_k};
         rsp_in.mult  = head.mult;
         rsp_in.low   = head.low;
         rsp_in.high  = head.high;
      end else begin
         rsp_in.depth = head.depth + 1'b1;
         rsp_in.idx_i = {head.idx_i, sel[2]};
         rsp_in.idx_j = {head.idx_j, sel[1]};
         rsp_in.idx_k = {head.idx_k, sel[0]};
         rsp_in.mult  = '0;
         for (int a = 0; a < 3; a++) begin
            if (a == 2 && head.plane) begin
               rsp_in.low[a]  = head.low[a];
               rsp_in.high[a] = head.high[a];
            end else begin
               rsp_in.low[a]  = sel[2 - a] ? head.mid[a] : head.low[a];
               rsp_in.high[a] = sel[2 - a] ? head.high[a] : head.mid[a];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit)
         rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
            started_ff   <= !last;
            rem_ff       <= rem_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> hw/rtl/octree_child_tile_subdivision.sv
// Top level of the octree child tile subdivision block.
//
//   channel  direction  handshake                 moves
//   req      in         req_valid / req_ready     one parent tile request
//   rsp      out        rsp_valid / rsp_ready     one child tile, rsp_last_child ends a parent
//   csr      in         csr_we                    one register write, index and data
//
// One child leaves per cycle while rsp_ready keeps the single output register free; a
// parent stays at the back end until each of its emitted children (1 to 8) has left.
// A leaf or fully skipped parent is accepted without entering the queue and gives no result.
// The first child is registered in the queue and then in the output register before it is valid.
// Synchronous reset clears the queue pointers and count, the output valid and the CSRs.
// A two-entry queue lets requests be taken while the output stalls.
module octree_child_tile_subdivision (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [octc_pkg::DEPTH_W-1:0]         req_parent_depth,
   input  logic [octc_pkg::PIDX_W-1:0]          req_parent_i,
   input  logic [octc_pkg::PIDX_W-1:0]          req_parent_j,
   input  logic [octc_pkg::PIDX_W-1:0]          req_parent_k,
   input  logic [octc_pkg::PMULT_W-1:0]         req_parent_mult,
   input  logic [octc_pkg::FLAGS_W-1:0]         req_leaf_and_empty,
   input  logic signed [octc_pkg::COORD_BITS-1:0] req_box_low_x,
   input  logic signed [octc_pkg::COORD_BITS-1:0] req_box_low_y,
   input  logic signed [octc_pkg::COORD_BITS-1:0] req_box_low_z,
   input  logic signed [octc_pkg::COORD_BITS-1:0] req_box_high_x,
   input  logic signed [octc_pkg::COORD_BITS-1:0] req_box_high_y,
   input  logic signed [octc_pkg::COORD_BITS-1:0] req_box_high_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [octc_pkg::DEPTH_W-1:0]         rsp_child_depth,
   output logic [octc_pkg::CIDX_W-1:0]          rsp_child_i,
   output logic [octc_pkg::CIDX_W-1:0]          rsp_child_j,
   output logic [octc_pkg::CIDX_W-1:0]          rsp_child_k,
   output logic [octc_pkg::CMULT_W-1:0]         rsp_child_mult,
   output logic signed [octc_pkg::COORD_BITS-1:0] rsp_out_low_x,
   output logic signed [octc_pkg::COORD_BITS-1:0] rsp_out_low_y,
   output logic signed [octc_pkg::COORD_BITS-1:0] rsp_out_low_z,
   output logic signed [octc_pkg::COORD_BITS-1:0] rsp_out_high_x,
   output logic signed [octc_pkg::COORD_BITS-1:0] rsp_out_high_y,
   output logic signed [octc_pkg::COORD_BITS-1:0] rsp_out_high_z,
   output logic                                 rsp_last_child,
   input  logic                                 csr_we,
   input  logic [octc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [octc_pkg::COORD_BITS-1:0]      csr_wdata
);
   import octc_pkg::*;

   octc_cfg_type    cfg_ff;
   coord_type [2:0] req_low;
   coord_type [2:0] req_high;
   logic            q_full;
   logic            q_push;
   octc_desc_type   q_data;
   logic            q_pop;
   logic            head_valid;
   octc_desc_type   head;
   octc_rsp_type    rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PLANE_MODE: cfg_ff.plane_mode <= csr_wdata[0];
            CSR_BOX_VALID:  cfg_ff.box_valid  <= csr_wdata[0];
            CSR_LOW_X:      cfg_ff.low[0]     <= csr_wdata;
            CSR_LOW_Y:      cfg_ff.low[1]     <= csr_wdata;
            CSR_LOW_Z:      cfg_ff.low[2]     <= csr_wdata;
            CSR_HIGH_X:     cfg_ff.high[0]    <= csr_wdata;
            CSR_HIGH_Y:     cfg_ff.high[1]    <= csr_wdata;
            CSR_HIGH_Z:     cfg_ff.high[2]    <= csr_wdata;
         endcase
      end
   end

   assign req_low  = {req_box_low_z, req_box_low_y, req_box_low_x};
   assign req_high = {req_box_high_z, req_box_high_y, req_box_high_x};

   octc_front u_front (
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_parent_depth   (req_parent_depth),
      .req_parent_i       (req_parent_i),
      .req_parent_j       (req_parent_j),
      .req_parent_k       (req_parent_k),
      .req_parent_mult    (req_parent_mult),
      .req_leaf_and_empty (req_leaf_and_empty),
      .req_low            (req_low),
      .req_high           (req_high),
      .cfg                (cfg_ff),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_data             (q_data)
   );

   octc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head       (head)
   );

   octc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   assign rsp_child_depth = rsp.depth;
   assign rsp_child_i     = rsp.idx_i;
   assign rsp_child_j     = rsp.idx_j;
   assign rsp_child_k     = rsp.idx_k;
   assign rsp_child_mult  = rsp.mult;
   assign rsp_out_low_x   = rsp.low[0];
   assign rsp_out_low_y   = rsp.low[1];
   assign rsp_out_low_z   = rsp.low[2];
   assign rsp_out_high_x  = rsp.high[0];
   assign rsp_out_high_y  = rsp.high[1];
   assign rsp_out_high_z  = rsp.high[2];
   assign rsp_last_child  = rsp.last;

endmodule

>>> hw/rtl/octc_checker.sv
// Port-level checks for the octree child tile subdivision block, bound to the top level.
module octc_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [octc_pkg::CMULT_W-1:0]         rsp_child_mult,
   input  logic                                 rsp_last_child,
   input  logic signed [octc_pkg::COORD_BITS-1:0] rsp_out_low_x
);
   import octc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_low_x)
                                  && $stable(rsp_last_child))
      else $error("response dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_magnify_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_child_mult != '0) |-> rsp_last_child && !rsp_child_mult[0])
      else $error("magnified child is not a lone even-multiplier response");

   a_split_mult_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_child |-> rsp_child_mult == '0)
      else $error("non-final child carries a multiplier");

endmodule

bind octree_child_tile_subdivision octc_checker u_octc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_child_mult (rsp_child_mult),
   .rsp_last_child (rsp_last_child),
   .rsp_out_low_x  (rsp_out_low_x)
);

>>> test/octree_child_tile_subdivision_tb.sv
// Self-checking testbench for the octree child tile subdivision block.
`timescale 1ns / 100ps

module octree_child_tile_subdivision_tb;
   import octc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 10;
   localparam logic signed [COORD_BITS-1:0] CMIN = 32'sh8000_0000;
   localparam logic signed [COORD_BITS-1:0] CMAX = 32'sh7fff_ffff;
   localparam logic [PIDX_W-1:0] IMAX = '1;

   typedef struct {
      logic [DEPTH_W-1:0]           depth;
      logic [PIDX_W-1:0]            idx [3];
      logic [PMULT_W-1:0]           mult;
      logic [FLAGS_W-1:0]           flags;
      logic signed [COORD_BITS-1:0] low [3];
      logic signed [COORD_BITS-1:0] high [3];
   } parent_tile_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [DEPTH_W-1:0]            req_parent_depth = '0;
   logic [PIDX_W-1:0]             req_parent_i = '0;
   logic [PIDX_W-1:0]             req_parent_j = '0;
   logic [PIDX_W-1:0]             req_parent_k = '0;
   logic [PMULT_W-1:0]            req_parent_mult = '0;
   logic [FLAGS_W-1:0]            req_leaf_and_empty = '0;
   logic signed [COORD_BITS-1:0]  req_box_low_x = '0;
   logic signed [COORD_BITS-1:0]  req_box_low_y = '0;
   logic signed [COORD_BITS-1:0]  req_box_low_z = '0;
   logic signed [COORD_BITS-1:0]  req_box_high_x = '0;
   logic signed [COORD_BITS-1:0]  req_box_high_y = '0;
   logic signed [COORD_BITS-1:0]  req_box_high_z = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [DEPTH_W-1:0]            rsp_child_depth;
   logic [CIDX_W-1:0]             rsp_child_i;
   logic [CIDX_W-1:0]             rsp_child_j;
   logic [CIDX_W-1:0]             rsp_child_k;
   logic [CMULT_W-1:0]            rsp_child_mult;
   logic signed [COORD_BITS-1:0]  rsp_out_low_x;
   logic signed [COORD_BITS-1:0]  rsp_out_low_y;
   logic signed [COORD_BITS-1:0]  rsp_out_low_z;
   logic signed [COORD_BITS-1:0]  rsp_out_high_x;
   logic signed [COORD_BITS-1:0]  rsp_out_high_y;
   logic signed [COORD_BITS-1:0]  rsp_out_high_z;
   logic                          rsp_last_child;
   logic                          csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [COORD_BITS-1:0]         csr_wdata = '0;

   // register shadow
   logic                          cfg_plane = 1'b0;
   logic                          cfg_box_valid = 1'b0;
   logic signed [COORD_BITS-1:0]  cfg_lo [3] = '{default: '0};
   logic signed [COORD_BITS-1:0]  cfg_hi [3] = '{default: '0};

   parent_tile_type pending_parents [$];
   octc_rsp_type expected_children [$];
   parent_tile_type offered;

   int  errors = 0;
   int  parents_accepted = 0;
   int  children_checked = 0;
   int  reg_writes = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_left = 0;
   int  idle_cycles = 0;
   bit  sender_quiet = 1'b0;
   bit  receiver_quiet = 1'b0;
   bit  hold_wanted = 1'b0;
   bit  hold_done = 1'b0;

   octree_child_tile_subdivision u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_parent_depth   (req_parent_depth),
      .req_parent_i       (req_parent_i),
      .req_parent_j       (req_parent_j),
      .req_parent_k       (req_parent_k),
      .req_parent_mult    (req_parent_mult),
      .req_leaf_and_empty (req_leaf_and_empty),
      .req_box_low_x      (req_box_low_x),
      .req_box_low_y      (req_box_low_y),
      .req_box_low_z      (req_box_low_z),
      .req_box_high_x     (req_box_high_x),
      .req_box_high_y     (req_box_high_y),
      .req_box_high_z     (req_box_high_z),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_child_depth    (rsp_child_depth),
      .rsp_child_i        (rsp_child_i),
      .rsp_child_j        (rsp_child_j),
      .rsp_child_k        (rsp_child_k),
      .rsp_child_mult     (rsp_child_mult),
      .rsp_out_low_x      (rsp_out_low_x),
      .rsp_out_low_y      (rsp_out_low_y),
      .rsp_out_low_z      (rsp_out_low_z),
      .rsp_out_high_x     (rsp_out_high_x),
      .rsp_out_high_y     (rsp_out_high_y),
      .rsp_out_high_z     (rsp_out_high_z),
      .rsp_last_child     (rsp_last_child),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Expected children of one parent, in i, j, k emission order.
   function automatic void split_parent(parent_tile_type p);
      logic signed [COORD_BITS:0]   sum;
      logic signed [COORD_BITS-1:0] mid [3];
      logic signed [COORD_BITS-1:0] clo [3];
      logic signed [COORD_BITS-1:0] chi [3];
      logic [2:0]   bits;
      logic         narrow;
      logic         hit;
      int           kmax;
      octc_rsp_type kid;
      octc_rsp_type kids [$];
      if (p.flags[8]) return;
      if (p.mult != 0) begin
         kid.depth = p.depth;
         kid.idx_i = {1'b0, p.idx[0]};
         kid.idx_j = {1'b0, p.idx[1]};
         kid.idx_k = {1'b0, p.idx[2]};
         kid.mult  = {p.mult, 1'b0};
         for (int a = 0; a < 3; a++) begin
            kid.low[a]  = p.low[a];
            kid.high[a] = p.high[a];
         end
         kid.last = 1'b1;
         expected_children.insert(expected_children.size(), kid);
         return;
      end
      narrow = 1'b0;
      for (int a = 0; a < 3; a++) begin
         sum = p.low[a] + p.high[a];
         mid[a] = sum[COORD_BITS:1];
         if (cfg_box_valid && !(cfg_lo[a] <= p.low[a] && p.high[a] <= cfg_hi[a]))
            narrow = 1'b1;
      end
      kmax = cfg_plane ? 1 : 2;
      for (int bi = 0; bi < 2; bi++) begin
         for (int bj = 0; bj < 2; bj++) begin
            for (int bk = 0; bk < kmax; bk++) begin
               bits = 3'(bi + 2 * bj + 4 * bk);
               if (p.flags[bits]) continue;
               hit = 1'b1;
               for (int a = 0; a < 3; a++) begin
                  clo[a] = p.low[a];
                  chi[a] = p.high[a];
                  if (!(a == 2 && cfg_plane)) begin
                     if (bits[a]) clo[a] = mid[a];
                     else chi[a] = mid[a];
                  end
                  if (!(clo[a] <= cfg_hi[a] && cfg_lo[a] <= chi[a])) hit = 1'b0;
               end
               if (narrow && !hit) continue;
               kid.depth = p.depth + 1'b1;
               kid.idx_i = {p.idx[0], bits[0]};
               kid.idx_j = {p.idx[1], bits[1]};
               kid.idx_k = {p.idx[2], bits[2]};
               kid.mult  = '0;
               for (int a = 0; a < 3; a++) begin
                  kid.low[a]  = clo[a];
                  kid.high[a] = chi[a];
               end
               kid.last = 1'b0;
               kids.insert(kids.size(), kid);
            end
         end
      end
      if (kids.size() > 0) kids[kids.size() - 1].last = 1'b1;
      foreach (kids[n]) expected_children.insert(expected_children.size(), kids[n]);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            split_parent(offered);
            parents_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_parents.size() > 0) begin
               offered = pending_parents.pop_front();
               req_parent_depth   <= offered.depth;
               req_parent_i       <= offered.idx[0];
               req_parent_j       <= offered.idx[1];
               req_parent_k       <= offered.idx[2];
               req_parent_mult    <= offered.mult;
               req_leaf_and_empty <= offered.flags;
               req_box_low_x      <= offered.low[0];
               req_box_low_y      <= offered.low[1];
               req_box_low_z      <= offered.low[2];
               req_box_high_x     <= offered.high[0];
               req_box_high_y     <= offered.high[1];
               req_box_high_z     <= offered.high[2];
               req_valid <= 1'b1;
               send_gap <= pick_gap(sender_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   task automatic check_child();
      octc_rsp_type want;
      if (expected_children.size() == 0) begin
         errors++;
         $display("%0t: child tile with no parent pending, expected none, actual i %0h j %0h k %0h",
                  $time, rsp_child_i, rsp_child_j, rsp_child_k);
         return;
      end
      want = expected_children.pop_front();
      children_checked++;
      check_field("child_depth", want.depth, rsp_child_depth);
      check_field("child_i", want.idx_i, rsp_child_i);
      check_field("child_j", want.idx_j, rsp_child_j);
      check_field("child_k", want.idx_k, rsp_child_k);
      check_field("child_mult", want.mult, rsp_child_mult);
      check_field("out_low_x", want.low[0], rsp_out_low_x);
      check_field("out_low_y", want.low[1], rsp_out_low_y);
      check_field("out_low_z", want.low[2], rsp_out_low_z);
      check_field("out_high_x", want.high[0], rsp_out_high_x);
      check_field("out_high_y", want.high[1], rsp_out_high_y);
      check_field("out_high_z", want.high[2], rsp_out_high_z);
      check_field("last_child", want.last, rsp_last_child);
   endtask

   // child monitor and receiver backpressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_child();
         if (hold_wanted && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            recv_gap <= pick_gap(receiver_quiet);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [COORD_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      reg_writes++;
      case (index)
         CSR_PLANE_MODE: cfg_plane = value[0];
         CSR_BOX_VALID:  cfg_box_valid = value[0];
         CSR_LOW_X:      cfg_lo[0] = value;
         CSR_LOW_Y:      cfg_lo[1] = value;
         CSR_LOW_Z:      cfg_lo[2] = value;
         CSR_HIGH_X:     cfg_hi[0] = value;
         CSR_HIGH_Y:     cfg_hi[1] = value;
         CSR_HIGH_Z:     cfg_hi[2] = value;
         default: ;
      endcase
   endtask

   task automatic set_content_box(logic signed [COORD_BITS-1:0] lx, ly, lz, hx, hy, hz);
      write_reg(CSR_LOW_X, lx);
      write_reg(CSR_LOW_Y, ly);
      write_reg(CSR_LOW_Z, lz);
      write_reg(CSR_HIGH_X, hx);
      write_reg(CSR_HIGH_Y, hy);
      write_reg(CSR_HIGH_Z, hz);
   endtask

   task automatic set_random_content_box();
      set_content_box(-int'($urandom_range(0, 600)), -int'($urandom_range(0, 600)),
                      -int'($urandom_range(0, 600)), $urandom_range(0, 600),
                      $urandom_range(0, 600), $urandom_range(0, 600));
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_parents.size() != 0 || req_valid || expected_children.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic parent_tile_type make_parent(
      logic [DEPTH_W-1:0] depth, logic [PIDX_W-1:0] pi, pj, pk,
      logic [PMULT_W-1:0] mult, logic [FLAGS_W-1:0] flags,
      logic signed [COORD_BITS-1:0] lx, ly, lz, hx, hy, hz);
      parent_tile_type p;
      p.depth = depth;
      p.idx[0] = pi;
      p.idx[1] = pj;
      p.idx[2] = pk;
      p.mult = mult;
      p.flags = flags;
      p.low[0] = lx;
      p.low[1] = ly;
      p.low[2] = lz;
      p.high[0] = hx;
      p.high[1] = hy;
      p.high[2] = hz;
      return p;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] rand_coord();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         case ($urandom_range(0, 3))
            0: return CMIN;
            1: return CMAX;
            2: return '0;
            default: return '1;
         endcase
      end
      if (r < 25) return $urandom;
      return int'($urandom_range(0, 2400)) - 1200;
   endfunction

   function automatic logic [PIDX_W-1:0] rand_index();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return IMAX;
      return $urandom_range(0, IMAX);
   endfunction

   function automatic parent_tile_type rand_parent();
      parent_tile_type p;
      int r;
      p.depth = $urandom_range(0, DEPTH_LIMIT);
      for (int a = 0; a < 3; a++) p.idx[a] = rand_index();
      r = $urandom_range(0, 99);
      if (r < 72) p.mult = '0;
      else if (r < 78) p.mult = 1;
      else if (r < 84) p.mult = 16'h8000;
      else p.mult = $urandom_range(1, 32768);
      r = $urandom_range(0, 99);
      p.flags[8] = (r < 8);
      r = $urandom_range(0, 99);
      if (r < 50) p.flags[7:0] = '0;
      else if (r < 58) p.flags[7:0] = '1;
      else p.flags[7:0] = $urandom_range(0, 255);
      for (int a = 0; a < 3; a++) begin
         p.low[a] = rand_coord();
         if ($urandom_range(0, 99) < 80) p.high[a] = p.low[a] + $urandom_range(0, 1200);
         else p.high[a] = rand_coord();
      end
      return p;
   endfunction

   task automatic add_parent(parent_tile_type p);
      pending_parents.insert(pending_parents.size(), p);
   endtask

   task automatic queue_random(int count);
      repeat (count) add_parent(rand_parent());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: volume tree, no content box
      add_parent(make_parent(5, 7, 8, 9, 0, 9'h100, 0, 0, 0, 10, 10, 10));
      add_parent(make_parent(3, 1, 2, 3, 5, 9'h1ff, 0, 0, 0, 10, 10, 10));
      add_parent(make_parent(0, 0, 0, 0, 1, 9'h000, -8, -8, -8, 8, 8, 8));
      add_parent(make_parent(23, IMAX, IMAX, IMAX, 16'h8000, 9'h000,
                             CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
      add_parent(make_parent(0, 0, 0, 0, 0, 9'h000, 0, 0, 0, 1000, 1000, 1000));
      add_parent(make_parent(23, IMAX, IMAX, IMAX, 0, 9'h000,
                             CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
      add_parent(make_parent(12, 5, 6, 7, 0, 9'h000,
                             CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
      add_parent(make_parent(12, 5, 6, 7, 0, 9'h000,
                             CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
      add_parent(make_parent(4, 9, 9, 9, 0, 9'h000, 100, 100, 100, -100, -100, -100));
      add_parent(make_parent(4, 2, 3, 4, 0, 9'h000, -3, -3, -3, 0, 0, 0));
      add_parent(make_parent(6, 1, 1, 1, 0, 9'h0ff, 0, 0, 0, 64, 64, 64));
      add_parent(make_parent(6, 1, 1, 1, 0, 9'h055, 0, 0, 0, 64, 64, 64));
      add_parent(make_parent(6, 1, 1, 1, 0, 9'h07f, 0, 0, 0, 64, 64, 64));
      add_parent(make_parent(6, 1, 1, 1, 0, 9'h0fe, 0, 0, 0, 64, 64, 64));
      add_parent(make_parent(9, 23'h2aaaaa, 23'h555555, 1, 16'h5555, 9'h000,
                             1, 2, 3, 4, 5, 6));
      add_parent(make_parent(1, 0, 1, 0, 0, 9'h000,
                             CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
      wait_idle();

      // quadtree, no content box; sender pauses halfway until drained
      sender_quiet = 1'b1;
      write_reg(CSR_PLANE_MODE, 1);
      write_reg(CSR_BOX_VALID, 0);
      add_parent(make_parent(2, 3, 3, 3, 0, 9'h0f0, 0, 0, 50, 40, 40, 90));
      add_parent(make_parent(2, 3, 3, 3, 0, 9'h00f, 0, 0, 50, 40, 40, 90));
      queue_random(30);
      wait_idle();
      queue_random(30);
      wait_idle();

      // volume tree culled by a content box; receiver holds off for a long stretch
      write_reg(CSR_PLANE_MODE, 0);
      write_reg(CSR_BOX_VALID, 1);
      set_content_box(-500, -500, -500, 500, 500, 500);
      add_parent(make_parent(3, 4, 4, 4, 0, 9'h000, -100, -100, -100, 100, 100, 100));
      add_parent(make_parent(3, 4, 4, 4, 0, 9'h000, -1002, -100, -100, 0, 100, 100));
      add_parent(make_parent(3, 4, 4, 4, 0, 9'h000, -1000, -100, -100, 0, 100, 100));
      add_parent(make_parent(3, 4, 4, 4, 0, 9'h000, 600, 600, 600, 900, 900, 900));
      add_parent(make_parent(3, 4, 4, 4, 0, 9'h000, -500, -500, -500, 500, 500, 500));
      add_parent(make_parent(3, 4, 4, 4, 7, 9'h000, 600, 600, 600, 900, 900, 900));
      hold_wanted = 1'b1;
      queue_random(70);
      wait_idle();

      // quadtree culled by a random content box
      sender_quiet = 1'b0;
      write_reg(CSR_PLANE_MODE, 1);
      set_random_content_box();
      queue_random(70);
      wait_idle();

      // content box spans the whole coordinate range
      receiver_quiet = 1'b1;
      write_reg(CSR_PLANE_MODE, 0);
      set_content_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
      queue_random(50);
      wait_idle();

      // inverted content box culls every subdivided child
      receiver_quiet = 1'b0;
      set_content_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
      queue_random(20);
      wait_idle();

      // point content box at the origin with the volume tree, then quadtree with a random box
      set_content_box(0, 0, 0, 0, 0, 0);
      queue_random(30);
      wait_idle();
      write_reg(CSR_PLANE_MODE, 1);
      set_random_content_box();
      queue_random(30);
      wait_idle();

      if (expected_children.size() != 0) begin
         errors++;
         $display("%0t: %0d child tiles expected, actual none", $time, expected_children.size());
      end
      $display("summary: %0d parent requests, %0d child tiles checked, %0d register writes",
               parents_accepted, children_checked, reg_writes);
      $display("summary: quadtree and octree, no culling, local/full/inverted/point content boxes");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
